@@ rtl/sfx_seq_pkg.sv @@
// shared types, constants and step rom for the sound effect step sequencer
package sfx_seq_pkg;

    // defaults for the top level parameters
    localparam int NUM_EFFECTS_DEF    = 14;
    localparam int STEP_ROM_DEPTH_DEF = 32;

    // rom contents and effect table sizes
    localparam int ROM_USED   = 25;
    localparam int KNOWN_IDS  = 14;
    localparam int PTR_W      = 5;
    localparam int DUR_W      = 5;
    localparam int PRIO_W     = 3;
    localparam int ID_W       = 4;

    // depth of the step command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_PLAY = 1'b1;

    // channel kinds
    localparam logic [1:0] KIND_PULSE = 2'd0;
    localparam logic [1:0] KIND_SWEEP = 2'd1;
    localparam logic [1:0] KIND_NOISE = 2'd2;

    // sound register addresses (low byte)
    localparam logic [5:0] ADDR_PULSE_SWEEP = 6'h10;
    localparam logic [5:0] ADDR_PULSE_SHAPE = 6'h11;
    localparam logic [5:0] ADDR_PULSE_ENV   = 6'h12;
    localparam logic [5:0] ADDR_PULSE_FLO   = 6'h13;
    localparam logic [5:0] ADDR_PULSE_FHI   = 6'h14;
    localparam logic [5:0] ADDR_NOISE_ENV   = 6'h21;
    localparam logic [5:0] ADDR_NOISE_SHAPE = 6'h22;
    localparam logic [5:0] ADDR_NOISE_TRIG  = 6'h23;

    // fixed register values
    localparam logic [7:0] SWEEP_ON   = 8'h2D;
    localparam logic [7:0] SWEEP_OFF  = 8'h00;
    localparam logic [7:0] LENGTH_BIT = 8'h80;

    // write slot indexes within a step start
    localparam logic [2:0] SLOT_LAST_NOISE = 3'd2;
    localparam logic [2:0] SLOT_LAST_PULSE = 3'd4;

    // request transaction
    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] effect_id;
    } sfx_in_t;

    // result transaction: one sound register write
    typedef struct packed {
        logic [5:0] reg_addr;
        logic [7:0] reg_value;
        logic       last_write;
    } sfx_out_t;

    // one step of the rom
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic [1:0]       kind;
        logic [7:0]       env;
        logic [7:0]       shape;
        logic [7:0]       flo;
        logic [2:0]       fhi;
        logic             last;
    } rom_step_t;

    // step start handed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] env;
        logic [7:0] shape;
        logic [7:0] flo;
        logic [2:0] fhi;
    } step_cmd_t;

    // silent one-frame noise step that ends its effect
    localparam rom_step_t STEP_BLANK = '{5'd1, KIND_NOISE, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1};

    // step rom
    function automatic rom_step_t rom_read(input logic [PTR_W-1:0] idx);
        rom_step_t s;
        case (idx)
            5'd0:    s = '{5'd4,  KIND_NOISE, 8'h52, 8'h62, 8'h00, 3'd0, 1'b1};
            5'd1:    s = '{5'd4,  KIND_NOISE, 8'h52, 8'h53, 8'h00, 3'd0, 1'b1};
            5'd2:    s = '{5'd3,  KIND_NOISE, 8'h31, 8'h25, 8'h00, 3'd0, 1'b0};
            5'd3:    s = '{5'd4,  KIND_NOISE, 8'h21, 8'h13, 8'h00, 3'd0, 1'b1};
            5'd4:    s = '{5'd4,  KIND_SWEEP, 8'hA1, 8'h00, 8'h80, 3'd5, 1'b1};
            5'd5:    s = '{5'd3,  KIND_PULSE, 8'h81, 8'h80, 8'hAC, 3'd7, 1'b0};
            5'd6:    s = '{5'd5,  KIND_PULSE, 8'h72, 8'h80, 8'h7B, 3'd7, 1'b1};
            5'd7:    s = '{5'd4,  KIND_PULSE, 8'h91, 8'h40, 8'hBE, 3'd7, 1'b0};
            5'd8:    s = '{5'd8,  KIND_PULSE, 8'hA2, 8'h40, 8'hCE, 3'd7, 1'b1};
            5'd9:    s = '{5'd5,  KIND_NOISE, 8'hA1, 8'h4E, 8'h00, 3'd0, 1'b0};
            5'd10:   s = '{5'd6,  KIND_NOISE, 8'hC1, 8'h5D, 8'h00, 3'd0, 1'b1};
            5'd11:   s = '{5'd6,  KIND_NOISE, 8'hF2, 8'h71, 8'h00, 3'd0, 1'b0};
            5'd12:   s = '{5'd8,  KIND_NOISE, 8'hA2, 8'h53, 8'h00, 3'd0, 1'b1};
            5'd13:   s = '{5'd6,  KIND_PULSE, 8'hA2, 8'h40, 8'h21, 3'd7, 1'b0};
            5'd14:   s = '{5'd6,  KIND_PULSE, 8'hA2, 8'h40, 8'h05, 3'd7, 1'b0};
            5'd15:   s = '{5'd8,  KIND_PULSE, 8'h92, 8'h40, 8'hD6, 3'd6, 1'b1};
            5'd16:   s = '{5'd3,  KIND_PULSE, 8'h71, 8'h40, 8'hC1, 3'd7, 1'b1};
            5'd17:   s = '{5'd18, KIND_NOISE, 8'h81, 8'h62, 8'h00, 3'd0, 1'b0};
            5'd18:   s = '{5'd18, KIND_NOISE, 8'h81, 8'h62, 8'h00, 3'd0, 1'b0};
            5'd19:   s = '{5'd18, KIND_NOISE, 8'h91, 8'h62, 8'h00, 3'd0, 1'b1};
            5'd20:   s = '{5'd4,  KIND_PULSE, 8'h91, 8'h80, 8'h05, 3'd7, 1'b0};
            5'd21:   s = '{5'd4,  KIND_PULSE, 8'h91, 8'h80, 8'h39, 3'd7, 1'b0};
            5'd22:   s = '{5'd4,  KIND_PULSE, 8'h91, 8'h80, 8'h59, 3'd7, 1'b0};
            5'd23:   s = '{5'd12, KIND_PULSE, 8'hA3, 8'h80, 8'h83, 3'd7, 1'b1};
            5'd24:   s = '{5'd4,  KIND_NOISE, 8'h31, 8'h24, 8'h00, 3'd0, 1'b1};
            default: s = STEP_BLANK;
        endcase
        return s;
    endfunction

    // first rom step of each effect
    function automatic logic [PTR_W-1:0] effect_start(input logic [ID_W-1:0] id);
        logic [PTR_W-1:0] p;
        case (id)
            4'd0:    p = 5'd0;
            4'd1:    p = 5'd0;
            4'd2:    p = 5'd1;
            4'd3:    p = 5'd2;
            4'd4:    p = 5'd4;
            4'd5:    p = 5'd5;
            4'd6:    p = 5'd7;
            4'd7:    p = 5'd9;
            4'd8:    p = 5'd11;
            4'd9:    p = 5'd13;
            4'd10:   p = 5'd16;
            4'd11:   p = 5'd17;
            4'd12:   p = 5'd20;
            4'd13:   p = 5'd24;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

    // priority of each effect
    function automatic logic [PRIO_W-1:0] effect_prio(input logic [ID_W-1:0] id);
        logic [PRIO_W-1:0] p;
        case (id)
            4'd0:    p = 3'd0;
            4'd1:    p = 3'd1;
            4'd2:    p = 3'd1;
            4'd3:    p = 3'd2;
            4'd4:    p = 3'd2;
            4'd5:    p = 3'd3;
            4'd6:    p = 3'd3;
            4'd7:    p = 3'd4;
            4'd8:    p = 3'd5;
            4'd9:    p = 3'd6;
            4'd10:   p = 3'd2;
            4'd11:   p = 3'd4;
            4'd12:   p = 3'd5;
            4'd13:   p = 3'd1;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/sfx_seq_front.sv @@
// front end: accepts requests and ticks, tracks the effect state, issues step starts
module sfx_seq_front #(
    parameter int NUM_EFFECTS    = sfx_seq_pkg::NUM_EFFECTS_DEF,
    parameter int STEP_ROM_DEPTH = sfx_seq_pkg::STEP_ROM_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sfx_seq_pkg::sfx_in_t  request,
    output logic                  cmd_push,
    output sfx_seq_pkg::step_cmd_t cmd,
    input  logic                  cmd_full
);

    logic                                active_reg, active_next;
    logic [sfx_seq_pkg::PTR_W-1:0]       ptr_reg, ptr_next;
    logic [sfx_seq_pkg::DUR_W-1:0]       frames_reg, frames_next;
    logic [sfx_seq_pkg::PRIO_W-1:0]      prio_reg, prio_next;
    logic [sfx_seq_pkg::ID_W-1:0]        pending_reg, pending_next;
    logic                                cur_last_reg, cur_last_next;

    logic                                accept;
    logic                                start_go;
    logic                                advance;
    logic [sfx_seq_pkg::ID_W-1:0]        start_id;
    logic [sfx_seq_pkg::DUR_W-1:0]       frames_dec;
    logic [sfx_seq_pkg::PTR_W-1:0]       rd_ptr;
    sfx_seq_pkg::rom_step_t              rd_step;

    // an id that names a real effect
    function automatic logic known_id(input logic [sfx_seq_pkg::ID_W-1:0] id);
        return (id != '0) && (32'(id) < NUM_EFFECTS) && (32'(id) < sfx_seq_pkg::KNOWN_IDS);
    endfunction

    assign accept     = push && !cmd_full;
    assign full       = cmd_full;
    assign frames_dec = frames_reg - 1'b1;

    // classify the transaction: start an effect, advance a step, or just update state
    always_comb
    begin
        start_go = 1'b0;
        advance  = 1'b0;
        start_id = request.effect_id;
        if (accept)
        begin
            if (request.func == sfx_seq_pkg::FUNC_PLAY)
            begin
                if (known_id(request.effect_id) && !active_reg)
                begin
                    start_go = 1'b1;
                end
            end
            else if (active_reg && frames_dec == '0)
            begin
                if (!cur_last_reg)
                begin
                    advance = 1'b1;
                end
                else if (pending_reg != '0 && known_id(pending_reg))
                begin
                    start_go = 1'b1;
                    start_id = pending_reg;
                end
            end
        end
    end

    // rom lookup of the step that starts now
    always_comb
    begin
        rd_ptr  = start_go ? sfx_seq_pkg::effect_start(start_id) : ptr_reg + 1'b1;
        rd_step = (32'(rd_ptr) < STEP_ROM_DEPTH) ? sfx_seq_pkg::rom_read(rd_ptr)
                                                 : sfx_seq_pkg::STEP_BLANK;
    end

    // next state
    always_comb
    begin
        active_next   = active_reg;
        ptr_next      = ptr_reg;
        frames_next   = frames_reg;
        prio_next     = prio_reg;
        pending_next  = pending_reg;
        cur_last_next = cur_last_reg;
        if (accept)
        begin
            if (request.func == sfx_seq_pkg::FUNC_PLAY)
            begin
                if (known_id(request.effect_id) && active_reg &&
                    sfx_seq_pkg::effect_prio(request.effect_id) >= prio_reg)
                begin
                    pending_next = request.effect_id;
                end
            end
            else if (active_reg)
            begin
                frames_next = frames_dec;
                if (frames_dec == '0 && cur_last_reg)
                begin
                    active_next  = 1'b0;
                    pending_next = '0;
                end
            end
        end
        if (start_go || advance)
        begin
            ptr_next      = rd_ptr;
            frames_next   = rd_step.dur;
            cur_last_next = rd_step.last;
        end
        if (start_go)
        begin
            active_next = 1'b1;
            prio_next   = sfx_seq_pkg::effect_prio(start_id);
        end
    end

    // step start command toward the queue
    assign cmd_push  = start_go || advance;
    assign cmd.kind  = rd_step.kind;
    assign cmd.env   = rd_step.env;
    assign cmd.shape = rd_step.shape;
    assign cmd.flo   = rd_step.flo;
    assign cmd.fhi   = rd_step.fhi;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            ptr_reg      <= '0;
            frames_reg   <= '0;
            prio_reg     <= '0;
            pending_reg  <= '0;
            cur_last_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            ptr_reg      <= ptr_next;
            frames_reg   <= frames_next;
            prio_reg     <= prio_next;
            pending_reg  <= pending_next;
            cur_last_reg <= cur_last_next;
        end
    end

    // a running step always has frames left
    assert property (@(posedge clk) disable iff (!rst_n) active_reg |-> frames_reg != '0)
        else $error("active effect with zero frames left");

    // a parked request exists only while an effect sounds
    assert property (@(posedge clk) disable iff (!rst_n) pending_reg != '0 |-> active_reg)
        else $error("pending effect while idle");

    // a step start is issued only for an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> push && !cmd_full)
        else $error("step start without accepted transaction");

endmodule

@@ rtl/sfx_seq_queue.sv @@
// short first-in first-out queue of step starts between front and back
module sfx_seq_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  sfx_seq_pkg::step_cmd_t wr_data,
    output logic                   q_full,
    input  logic                   rd_en,
    output sfx_seq_pkg::step_cmd_t rd_data,
    output logic                   q_avail
);

    localparam int DEPTH = sfx_seq_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    sfx_seq_pkg::step_cmd_t slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_avail = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_avail;
    assign rd_data = slots_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // fill count never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue overfilled");

    // a write into a full queue is never requested
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !wr_en)
        else $error("write into full queue");

    // pointers meet when the fill count is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

@@ rtl/sfx_seq_back.sv @@
// back end: expands one step start into its sound register writes
module sfx_seq_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_avail,
    input  sfx_seq_pkg::step_cmd_t q_data,
    output logic                   q_pop,
    output logic                   empty,
    input  logic                   pop,
    output sfx_seq_pkg::sfx_out_t  result
);

    sfx_seq_pkg::step_cmd_t cmd_reg;
    logic                   busy_reg, busy_next;
    logic [2:0]             slot_reg, slot_next;
    logic                   is_noise;
    logic                   at_last;
    logic                   taken;
    logic                   load;

    assign is_noise = (cmd_reg.kind == sfx_seq_pkg::KIND_NOISE);
    assign at_last  = is_noise ? (slot_reg == sfx_seq_pkg::SLOT_LAST_NOISE)
                               : (slot_reg == sfx_seq_pkg::SLOT_LAST_PULSE);
    assign taken    = pop && busy_reg;
    assign load     = q_avail && (!busy_reg || (taken && at_last));
    assign q_pop    = load;
    assign empty    = !busy_reg;

    // write sequence position
    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (load)
        begin
            busy_next = 1'b1;
            slot_next = '0;
        end
        else if (taken)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    // register write selected by the position
    always_comb
    begin
        result.last_write = at_last;
        result.reg_addr   = sfx_seq_pkg::ADDR_NOISE_TRIG;
        result.reg_value  = sfx_seq_pkg::LENGTH_BIT;
        if (is_noise)
        begin
            case (slot_reg)
                3'd0:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_NOISE_ENV;
                    result.reg_value = cmd_reg.env;
                end
                3'd1:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_NOISE_SHAPE;
                    result.reg_value = cmd_reg.shape;
                end
                default:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_NOISE_TRIG;
                    result.reg_value = sfx_seq_pkg::LENGTH_BIT;
                end
            endcase
        end
        else
        begin
            case (slot_reg)
                3'd0:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_PULSE_SWEEP;
                    result.reg_value = (cmd_reg.kind == sfx_seq_pkg::KIND_SWEEP)
                                       ? sfx_seq_pkg::SWEEP_ON : sfx_seq_pkg::SWEEP_OFF;
                end
                3'd1:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_PULSE_SHAPE;
                    result.reg_value = cmd_reg.shape;
                end
                3'd2:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_PULSE_ENV;
                    result.reg_value = cmd_reg.env;
                end
                3'd3:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_PULSE_FLO;
                    result.reg_value = cmd_reg.flo;
                end
                default:
                begin
                    result.reg_addr  = sfx_seq_pkg::ADDR_PULSE_FHI;
                    result.reg_value = sfx_seq_pkg::LENGTH_BIT | {5'd0, cmd_reg.fhi};
                end
            endcase
        end
    end

    // current step start
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= q_data;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    // position stays inside the write list of the step kind
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (is_noise ? slot_reg <= sfx_seq_pkg::SLOT_LAST_NOISE
                               : slot_reg <= sfx_seq_pkg::SLOT_LAST_PULSE))
        else $error("write position beyond step write list");

    // a popped non-final write is followed by the next position of the same step
    assert property (@(posedge clk) disable iff (!rst_n)
        taken && !at_last |=> busy_reg && slot_reg == $past(slot_reg) + 3'd1)
        else $error("write sequence skipped a position");

    // a new step start begins at its first write
    assert property (@(posedge clk) disable iff (!rst_n) load |=> slot_reg == '0)
        else $error("step start did not begin at first write");

endmodule

@@ rtl/sound_effect_step_sequencer.sv @@
// top level of the sound effect step sequencer
// Plays one sound effect at a time from a built-in step rom. A request
// transaction (func=1) starts its effect at once when idle, or parks it in a
// single pending slot when an effect of no higher priority is sounding; a
// tick transaction (func=0) counts the current step down and, when it runs
// out, moves to the next step or ends the effect and starts the pending one.
// Each step start produces three (noise) or five (pulse or sweep) sound
// register writes, read out one per cycle while pop is held, as result
// transactions. The front end takes one transaction per cycle while full is
// low and issues at most one step start each; step starts wait in a
// two-entry queue, so full rises only while two step starts are waiting.
// The output side delivers one write per cycle while pop is held; that single
// write port sets the sustained rate when every transaction starts a step.
module sound_effect_step_sequencer #(
    parameter int NUM_EFFECTS    = sfx_seq_pkg::NUM_EFFECTS_DEF,
    parameter int STEP_ROM_DEPTH = sfx_seq_pkg::STEP_ROM_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sfx_seq_pkg::sfx_in_t  request,
    output logic                  empty,
    input  logic                  pop,
    output sfx_seq_pkg::sfx_out_t result
);

    logic                   cmd_push;
    sfx_seq_pkg::step_cmd_t cmd;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_avail;
    sfx_seq_pkg::step_cmd_t q_data;

    // request handling and effect state
    sfx_seq_front #(
        .NUM_EFFECTS    (NUM_EFFECTS),
        .STEP_ROM_DEPTH (STEP_ROM_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .cmd_push (cmd_push),
        .cmd      (cmd),
        .cmd_full (q_full)
    );

    // step start queue
    sfx_seq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_avail (q_avail)
    );

    // register write sequencing
    sfx_seq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
